/* design/tlbr_pkg.sv */
package tlbr_pkg;

  localparam int PADDR_W = 17;
  localparam int CNT_W   = 32;
  localparam int STAMP_W = 64;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TLB,
    S_SCAN,
    S_FILL,
    S_DONE
  } tlbr_state_t;

endpackage

/* design/tlbr_in_if.sv */
interface tlbr_in_if #(
  parameter int PID_BITS   = 16,
  parameter int VADDR_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic [PID_BITS-1:0]   pid;
  logic [VADDR_BITS-1:0] vaddr;

  modport source (output valid, output pid, output vaddr, input ready);
  modport sink   (input valid, input pid, input vaddr, output ready);
endinterface

/* design/tlbr_out_if.sv */
interface tlbr_out_if;
  import tlbr_pkg::*;
  logic               valid;
  logic               ready;
  logic [PADDR_W-1:0] paddr;
  logic               fault;
  logic               tlb_hit;
  logic [CNT_W-1:0]   hit_count;
  logic [CNT_W-1:0]   miss_count;

  modport source (output valid, output paddr, output fault, output tlb_hit,
                  output hit_count, output miss_count, input ready);
  modport sink   (input valid, input paddr, input fault, input tlb_hit,
                  input hit_count, input miss_count, output ready);
endinterface

/* design/tlb_lru_inverted_page_translator_core.sv */
// Translates a (pid, virtual address) word into a physical address through a
// small fully associative TLB with LRU replacement, backed by an inverted page
// table held in a single-port synchronous RAM with one entry per frame. A TLB
// hit passes from acceptance through the compare and done states to the output
// register. A miss walks the used frames of the table one RAM read per cycle
// while the LRU victim is picked one TLB slot per cycle, and fills the TLB once
// both are done. Frames are allocated from the top index downward, so the used
// frames are exactly those at or above the free count and the table needs no
// clearing after reset. One word is in flight at a time; the output register
// lets a new word be accepted while a finished result still waits.
module tlb_lru_inverted_page_translator_core #(
  parameter int TLB_ENTRIES = 4,
  parameter int FRAME_COUNT = 32,
  parameter int OFFSET_BITS = 12,
  parameter int VADDR_BITS  = 32,
  parameter int PID_BITS    = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  tlbr_in_if.sink    in_s,
  tlbr_out_if.source out_m
);
  import tlbr_pkg::*;

  localparam int PAGE_W = VADDR_BITS - OFFSET_BITS;
  localparam int FW     = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int FCW    = $clog2(FRAME_COUNT + 1);
  localparam int TIW    = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int VCW    = $clog2(TLB_ENTRIES + 1);
  localparam int XW     = PADDR_W + FW + OFFSET_BITS;

  typedef struct packed {
    logic [PID_BITS-1:0] owner;
    logic [PAGE_W-1:0]   page;
  } fentry_t;

  tlbr_state_t state_r, state_nxt;

  logic [PID_BITS-1:0]    tlb_owner_r [TLB_ENTRIES];
  logic [PAGE_W-1:0]      tlb_page_r  [TLB_ENTRIES];
  logic [FW-1:0]          tlb_frame_r [TLB_ENTRIES];
  logic [STAMP_W-1:0]     tlb_stamp_r [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] tlb_valid_r;

  logic [STAMP_W-1:0] lru_clock_r;
  logic [FCW-1:0]     free_count_r;
  logic [CNT_W-1:0]   hits_r, misses_r;

  fentry_t fmem [FRAME_COUNT];
  fentry_t rdata_r;
  logic    rd_en, wr_en;
  logic [FW-1:0] rd_addr, wr_addr;

  logic [PID_BITS-1:0]    pid_r;
  logic [PAGE_W-1:0]      page_r;
  logic [OFFSET_BITS-1:0] off_r;

  logic [FCW-1:0]     fidx_r;
  logic               rvld_r;
  logic [FW-1:0]      ridx_r;
  logic               ffound_r;
  logic [FW-1:0]      fframe_r;
  logic [VCW-1:0]     vidx_r;
  logic               vdone_r;
  logic [TIW-1:0]     victim_r;
  logic [STAMP_W-1:0] vbest_r;

  logic [FW-1:0] frame_r;
  logic          fault_r, hit_r;

  logic               out_valid_r;
  logic [PADDR_W-1:0] out_paddr_r;
  logic               out_fault_r, out_hit_r;
  logic [CNT_W-1:0]   out_hits_r, out_misses_r;

  // TLB compare, first matching slot wins.
  logic [TLB_ENTRIES-1:0] hit_vec;
  logic [TIW-1:0]         hit_idx;
  always_comb begin
    hit_idx = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      hit_vec[i] = tlb_valid_r[i] && tlb_owner_r[i] == pid_r && tlb_page_r[i] == page_r;
      if (hit_vec[i]) begin
        hit_idx = TIW'(i);
      end
    end
  end

  logic [TIW-1:0] vsel;
  logic           rmatch, fdone, fidx_end, out_free, no_frame;
  logic [FCW-1:0] fc_m1;
  assign vsel     = vidx_r[TIW-1:0];
  assign rmatch   = rvld_r && rdata_r.owner == pid_r && rdata_r.page == page_r;
  assign fidx_end = (fidx_r == FCW'(FRAME_COUNT));
  assign fdone    = ffound_r || (fidx_end && !rvld_r);
  assign out_free = !out_valid_r || out_m.ready;
  assign fc_m1    = free_count_r - 1'b1;
  assign no_frame = (free_count_r == '0);

  assign in_s.ready = (state_r == S_IDLE);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_s.valid) state_nxt = S_TLB;
      S_TLB:  state_nxt = (|hit_vec) ? S_DONE : S_SCAN;
      S_SCAN: if (fdone && vdone_r) state_nxt = S_FILL;
      S_FILL: state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Table RAM port controls.
  always_comb begin
    rd_en   = (state_r == S_SCAN) && !ffound_r && !rmatch && !fidx_end;
    rd_addr = fidx_r[FW-1:0];
    wr_en   = (state_r == S_FILL) && !ffound_r && !no_frame;
    wr_addr = fc_m1[FW-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fmem[wr_addr] <= '{owner: pid_r, page: page_r};
    end
    if (rd_en) begin
      rdata_r <= fmem[rd_addr];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      tlb_valid_r  <= '0;
      lru_clock_r  <= '0;
      free_count_r <= FCW'(FRAME_COUNT);
      hits_r       <= '0;
      misses_r     <= '0;
      out_valid_r  <= 1'b0;
      rvld_r       <= 1'b0;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        tlb_stamp_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      rvld_r  <= rd_en;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_m.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_TLB: begin
          if (|hit_vec) begin
            lru_clock_r          <= lru_clock_r + 1'b1;
            tlb_stamp_r[hit_idx] <= lru_clock_r + 1'b1;
            hits_r               <= hits_r + 1'b1;
          end else begin
            misses_r <= misses_r + 1'b1;
          end
        end
        S_FILL: begin
          if (ffound_r || !no_frame) begin
            tlb_valid_r[victim_r] <= 1'b1;
            tlb_stamp_r[victim_r] <= lru_clock_r;
          end
          if (wr_en) begin
            free_count_r <= fc_m1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        pid_r  <= in_s.pid;
        page_r <= in_s.vaddr[VADDR_BITS-1:OFFSET_BITS];
        off_r  <= in_s.vaddr[OFFSET_BITS-1:0];
      end
      S_TLB: begin
        frame_r  <= tlb_frame_r[hit_idx];
        hit_r    <= |hit_vec;
        fault_r  <= 1'b0;
        fidx_r   <= free_count_r;
        ffound_r <= 1'b0;
        vidx_r   <= '0;
        vdone_r  <= 1'b0;
        victim_r <= '0;
      end
      S_SCAN: begin
        if (rmatch && !ffound_r) begin
          ffound_r <= 1'b1;
          fframe_r <= ridx_r;
        end
        if (rd_en) begin
          fidx_r <= fidx_r + 1'b1;
          ridx_r <= rd_addr;
        end
        // Victim pick: first invalid slot, else first slot with the least stamp.
        if (!vdone_r) begin
          if (!tlb_valid_r[vsel]) begin
            victim_r <= vsel;
            vdone_r  <= 1'b1;
          end else begin
            if (vidx_r == '0 || tlb_stamp_r[vsel] < vbest_r) begin
              vbest_r  <= tlb_stamp_r[vsel];
              victim_r <= vsel;
            end
            if (vidx_r == VCW'(TLB_ENTRIES - 1)) begin
              vdone_r <= 1'b1;
            end
          end
          vidx_r <= vidx_r + 1'b1;
        end
      end
      S_FILL: begin
        fault_r <= !ffound_r && no_frame;
        frame_r <= ffound_r ? fframe_r : fc_m1[FW-1:0];
        if (ffound_r || !no_frame) begin
          tlb_owner_r[victim_r] <= pid_r;
          tlb_page_r[victim_r]  <= page_r;
          tlb_frame_r[victim_r] <= ffound_r ? fframe_r : fc_m1[FW-1:0];
        end
      end
      S_DONE: begin
        if (out_free) begin
          logic [XW-1:0] pa_wide;
          pa_wide      = XW'({frame_r, off_r});
          out_paddr_r  <= fault_r ? '0 : pa_wide[PADDR_W-1:0];
          out_fault_r  <= fault_r;
          out_hit_r    <= hit_r;
          out_hits_r   <= hits_r;
          out_misses_r <= misses_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_m.valid      = out_valid_r;
  assign out_m.paddr      = out_paddr_r;
  assign out_m.fault      = out_fault_r;
  assign out_m.tlb_hit    = out_hit_r;
  assign out_m.hit_count  = out_hits_r;
  assign out_m.miss_count = out_misses_r;

  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_count_r <= FCW'(FRAME_COUNT))
    else $error("free frame count above frame count");

  a_free_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (free_count_r == $past(free_count_r) ||
              free_count_r == $past(free_count_r) - 1'b1))
    else $error("free frame count moved by more than one");

  a_hit_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_fault_r && out_hit_r))
    else $error("result flagged as both hit and fault");

  a_fault_keeps_tlb: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL && !ffound_r && no_frame) |=> $stable(tlb_valid_r))
    else $error("TLB changed on a fault");

endmodule
